@@ rtl/core/temperature_rise_event_detector_macros.svh @@
// assertion macros for the temperature rise event detector
// used by rtl/core/temperature_rise_event_detector.sv, expects clk and rst_n in scope
`ifndef TEMPERATURE_RISE_EVENT_DETECTOR_MACROS_SVH
`define TEMPERATURE_RISE_EVENT_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define TRED_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TRED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TRED_ASSERT_IMPL(label, ante, cons, msg)
`define TRED_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/tred_pkg.sv @@
// shared types and constants of the temperature rise event detector
// no dependencies; used by temperature_rise_event_detector.sv
`default_nettype none

package tred_pkg;

  // field widths
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned MARGIN_W  = 16;
  localparam int unsigned OUT_SUM_W = 17;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned MAX_CODE  = 4095;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOT_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_MARGIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MARGIN = 2'd2;

  // register reset values
  localparam logic [SAMPLE_W-1:0] HOT_LEVEL_RST     = 12'd819;
  localparam logic [MARGIN_W-1:0] RISE_MARGIN_RST   = 16'd328;
  localparam logic [MARGIN_W-1:0] SETTLE_MARGIN_RST = 16'd109;

  // reported phase codes
  localparam logic [PHASE_W-1:0] CODE_WARMUP   = 2'd0;
  localparam logic [PHASE_W-1:0] CODE_WAITING  = 2'd1;
  localparam logic [PHASE_W-1:0] CODE_RUNNING  = 2'd2;
  localparam logic [PHASE_W-1:0] CODE_FINISHED = 2'd3;

  // detector phase, one-hot
  typedef enum logic [3:0] {
    PH_WARMUP   = 4'b0001,
    PH_WAITING  = 4'b0010,
    PH_RUNNING  = 4'b0100,
    PH_FINISHED = 4'b1000
  } phase_t;

  // phase to reported code
  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_WARMUP:   code = CODE_WARMUP;
      PH_WAITING:  code = CODE_WAITING;
      PH_RUNNING:  code = CODE_RUNNING;
      PH_FINISHED: code = CODE_FINISHED;
      default:     code = CODE_WARMUP;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/temperature_rise_event_detector.sv @@
// temperature rise event detector: windowed mean and four-phase event detector
// depends on tred_pkg.sv and temperature_rise_event_detector_macros.svh
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata: sample_code[11:0]
//  out_    | out | out_tvalid/tready  | out_tdata: window_sum[16:0], phase, fire_pulse
//  cfg_    | in  | cfg_we             | cfg_addr register index, cfg_wdata value
//
// one beat per cycle unless out_tready stalls; each beat passes stage 1, stage 2
// and the output register. The delay line sits in one memory with a registered
// read port: the oldest code is read at accept and written over when the beat
// leaves stage 1. Reset is synchronous; no clearing pass, a first-pass flag
// makes unwritten entries read as zero. Stages advance independently, so bubbles
// close up under out_tready stalls and input is taken while a result waits.
`default_nettype none
`include "temperature_rise_event_detector_macros.svh"

module temperature_rise_event_detector #(
  parameter int unsigned WINDOW = 30
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: sample_code[11:0], zero pad [15:12]
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  input  wire logic [tred_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: window_sum[16:0], phase[18:17], fire_pulse[19], zero pad [23:20]
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  output      logic [tred_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [tred_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [tred_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  localparam int unsigned SW     = tred_pkg::SAMPLE_W;
  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = $clog2(WINDOW * tred_pkg::MAX_CODE + 1);
  localparam int unsigned RM_W   = tred_pkg::MARGIN_W + CNT_W;
  localparam int unsigned CMP_W  = (SUM_W + 5 > RM_W + 1) ? SUM_W + 5 : RM_W + 1;
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * tred_pkg::MAX_CODE);

  // configuration registers and scaled margins
  logic [SW-1:0]                 hot_r;
  logic [tred_pkg::MARGIN_W-1:0] rise_r, settle_r;
  logic [RM_W-1:0]               rise_w_r, settle_w_r;

  // front end and stage registers
  logic              [PTR_W-1:0] ptr_r;
  logic                          filled_r;
  logic                          v1_r, v2_r;
  logic              [SW-1:0]    s1_sample_r, s2_sample_r;
  logic              [SUM_W-1:0] s1_ws_r, s2_ws_r;
  logic                          s1_fill_r;
  logic              [PTR_W-1:0] s1_slot_r;
  logic              [SW-1:0]    rd_data_r;
  logic              [SUM_W-1:0] sum_r, s2_sum_r;

  // detector state and output register
  tred_pkg::phase_t              phase_r;
  logic              [CNT_W-1:0] warm_r;
  logic                          out_valid_r;
  logic [tred_pkg::OUT_SUM_W-1:0] out_sum_r;
  logic [tred_pkg::PHASE_W-1:0]  out_phase_r;
  logic                          out_fire_r;

  // delay line storage
  logic [SW-1:0] line_mem [WINDOW];

  // pipeline flow control
  logic go_out, ld2, ld1, acc, mv1, mv2;
  assign go_out    = !out_valid_r || out_tready;
  assign ld2       = !v2_r || go_out;
  assign ld1       = !v1_r || ld2;
  assign acc       = in_tvalid && ld1;
  assign mv1       = v1_r && ld2;
  assign mv2       = v2_r && go_out;
  assign in_tready = ld1;

  // configuration writes, indexes beyond the list ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_r    <= tred_pkg::HOT_LEVEL_RST;
      rise_r   <= tred_pkg::RISE_MARGIN_RST;
      settle_r <= tred_pkg::SETTLE_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tred_pkg::REG_HOT_LEVEL:     hot_r    <= cfg_wdata[SW-1:0];
        tred_pkg::REG_RISE_MARGIN:   rise_r   <= cfg_wdata;
        tred_pkg::REG_SETTLE_MARGIN: settle_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // margins times window, constant multiply
  always_ff @(posedge clk) begin
    rise_w_r   <= RM_W'(rise_r) * RM_W'(WINDOW);
    settle_w_r <= RM_W'(settle_r) * RM_W'(WINDOW);
  end

  // write pointer and first-pass flag
  logic [PTR_W-1:0] ptr_nxt;
  logic             wrap;
  assign wrap    = (ptr_r == PTR_W'(WINDOW - 1));
  assign ptr_nxt = wrap ? '0 : ptr_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      filled_r <= 1'b0;
    end else if (acc) begin
      ptr_r <= ptr_nxt;
      if (wrap) begin
        filled_r <= 1'b1;
      end
    end
  end

  // delay line memory: read oldest at accept, overwrite one stage later
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data_r <= line_mem[ptr_r];
    end
    if (mv1) begin
      line_mem[s1_slot_r] <= s1_sample_r;
    end
  end

  // stage 1: sample, its scaled value, slot
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_sample_r <= in_tdata[SW-1:0];
      s1_ws_r     <= SUM_W'(in_tdata[SW-1:0]) * SUM_W'(WINDOW);
      s1_fill_r   <= filled_r;
      s1_slot_r   <= ptr_r;
    end
  end

  // running sum update
  logic [SW-1:0]    old_code;
  logic [SUM_W-1:0] sum_nxt;
  assign old_code = s1_fill_r ? rd_data_r : '0;
  assign sum_nxt  = sum_r - SUM_W'(old_code) + SUM_W'(s1_sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (mv1) begin
      sum_r <= sum_nxt;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_sample_r <= s1_sample_r;
      s2_ws_r     <= s1_ws_r;
      s2_sum_r    <= sum_nxt;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= acc;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (go_out) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // sample minus mean, scaled by sixteen times the window
  logic signed [SUM_W:0]   diff;
  logic signed [CMP_W-1:0] excess, rise_cmp, settle_cmp;
  logic                    rise_ok, settle_ok, hot_ok;
  assign diff       = $signed({1'b0, s2_ws_r}) - $signed({1'b0, s2_sum_r});
  assign excess     = CMP_W'(diff) <<< 4;
  assign rise_cmp   = CMP_W'($signed({1'b0, rise_w_r}));
  assign settle_cmp = CMP_W'($signed({1'b0, settle_w_r}));
  assign rise_ok    = excess > rise_cmp;
  assign settle_ok  = excess < settle_cmp;
  assign hot_ok     = s2_sample_r > hot_r;

  // detector phase step
  tred_pkg::phase_t ph_mid, phase_nxt;
  logic [CNT_W-1:0] warm_mid, warm_nxt;
  logic             fire_nxt;

  always_comb begin
    ph_mid   = phase_r;
    warm_mid = warm_r;
    if (phase_r == tred_pkg::PH_WARMUP) begin
      if (warm_r != '0) begin
        warm_mid = warm_r - CNT_W'(1);
      end
      if (warm_mid == '0) begin
        ph_mid = tred_pkg::PH_WAITING;
      end
    end
    phase_nxt = ph_mid;
    warm_nxt  = warm_mid;
    fire_nxt  = 1'b0;
    unique case (ph_mid)
      tred_pkg::PH_WARMUP: ;
      tred_pkg::PH_WAITING: begin
        if (hot_ok && rise_ok) begin
          phase_nxt = tred_pkg::PH_RUNNING;
        end
      end
      tred_pkg::PH_RUNNING: begin
        if (settle_ok) begin
          phase_nxt = tred_pkg::PH_FINISHED;
        end
      end
      tred_pkg::PH_FINISHED: begin
        fire_nxt  = 1'b1;
        phase_nxt = tred_pkg::PH_WARMUP;
        warm_nxt  = CNT_W'(WINDOW);
      end
      default: phase_nxt = tred_pkg::PH_WARMUP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tred_pkg::PH_WARMUP;
      warm_r  <= CNT_W'(WINDOW);
    end else if (mv2) begin
      phase_r <= phase_nxt;
      warm_r  <= warm_nxt;
    end
  end

  // output register
  logic [SUM_W+tred_pkg::OUT_SUM_W-1:0] sum_ext;
  assign sum_ext = {{tred_pkg::OUT_SUM_W{1'b0}}, s2_sum_r};

  always_ff @(posedge clk) begin
    if (mv2) begin
      out_sum_r   <= sum_ext[tred_pkg::OUT_SUM_W-1:0];
      out_phase_r <= tred_pkg::phase_code(phase_nxt);
      out_fire_r  <= fire_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_fire_r, out_phase_r, out_sum_r};

  // checks
  `TRED_ASSERT_IMPL(a_no_slot_clash, acc && mv1, s1_slot_r != ptr_r,
                    "delay line read and write hit the same slot")
  `TRED_ASSERT_IMPL(a_count_in_warmup, warm_r != '0, phase_r == tred_pkg::PH_WARMUP,
                    "warm-up count running outside warm-up")
  `TRED_ASSERT_IMPL(a_sum_bound, 1'b1, sum_r <= SUM_MAX,
                    "running sum beyond window full scale")
  `TRED_ASSERT_IMPL(a_fire_rearms, out_valid_r && out_fire_r,
                    out_phase_r == tred_pkg::CODE_WARMUP,
                    "pulse without return to warm-up")
  `TRED_ASSERT_NEXT(a_stage_fill, acc, v1_r,
                    "accepted beat missing from first stage")

endmodule

`default_nettype wire

@@ sim/tred_event_checker.sv @@
// result checker for the temperature rise event detector: watches all three channels,
// keeps its own copy of the window, sum and detector phase, and compares every result beat
// depends on tred_pkg.sv
`timescale 1ns / 100ps

module tred_event_checker
  import tred_pkg::*;
#(
  parameter int unsigned WINDOW = 30
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DAT_W-1:0]   cfg_wdata,
  output int                     mismatches,
  output int                     pending
);

  typedef struct packed {
    logic [OUT_SUM_W-1:0] sum;
    logic [PHASE_W-1:0]   phase;
    logic                 fire;
  } reading_t;

  // predictor state
  logic [SAMPLE_W-1:0] line_codes [WINDOW];
  int unsigned         line_slot;
  int unsigned         window_total;
  logic [PHASE_W-1:0]  det_phase;
  int unsigned         warm_left;
  logic [SAMPLE_W-1:0] hot_level;
  logic [MARGIN_W-1:0] rise_margin;
  logic [MARGIN_W-1:0] settle_margin;

  reading_t    expected_readings[$];
  int unsigned beats_in  = 0;
  int unsigned beats_out = 0;

  assign pending = int'(beats_in - beats_out);

  // window update and detector step for one sample
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] code);
    reading_t r;
    longint   excess;
    window_total = window_total - line_codes[line_slot] + code;
    line_codes[line_slot] = code;
    line_slot = (line_slot + 1 >= WINDOW) ? 0 : line_slot + 1;
    // sample minus mean, scaled by 16 * WINDOW, kept signed throughout
    excess = longint'(code) * 16 * longint'(WINDOW) - longint'(window_total) * 16;
    r.fire = 1'b0;
    if (det_phase == CODE_WARMUP) begin
      if (warm_left > 0) warm_left--;
      if (warm_left == 0) det_phase = CODE_WAITING;
    end
    if (det_phase == CODE_WAITING) begin
      if (code > hot_level && excess > longint'(rise_margin) * longint'(WINDOW))
        det_phase = CODE_RUNNING;
    end else if (det_phase == CODE_RUNNING) begin
      if (excess < longint'(settle_margin) * longint'(WINDOW))
        det_phase = CODE_FINISHED;
    end else if (det_phase == CODE_FINISHED) begin
      r.fire    = 1'b1;
      det_phase = CODE_WARMUP;
      warm_left = WINDOW;
    end
    r.sum   = window_total[OUT_SUM_W-1:0];
    r.phase = det_phase;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    int       errs;
    if (!rst_n) begin
      foreach (line_codes[i]) line_codes[i] = '0;
      line_slot     = 0;
      window_total  = 0;
      det_phase     = CODE_WARMUP;
      warm_left     = WINDOW;
      hot_level     = HOT_LEVEL_RST;
      rise_margin   = RISE_MARGIN_RST;
      settle_margin = SETTLE_MARGIN_RST;
      mismatches    = 0;
      expected_readings.delete();
      beats_in  <= 0;
      beats_out <= 0;
    end else begin
      // register writes, low bits kept, unknown index ignored
      if (cfg_we) begin
        case (cfg_addr)
          REG_HOT_LEVEL:     hot_level     = cfg_wdata[SAMPLE_W-1:0];
          REG_RISE_MARGIN:   rise_margin   = cfg_wdata[MARGIN_W-1:0];
          REG_SETTLE_MARGIN: settle_margin = cfg_wdata[MARGIN_W-1:0];
          default: ;
        endcase
      end
      // input beat
      if (in_tvalid && in_tready) begin
        expected_readings.push_back(predict_reading(in_tdata[SAMPLE_W-1:0]));
        beats_in <= beats_in + 1;
      end
      // result beat
      if (out_tvalid && out_tready) begin
        beats_out <= beats_out + 1;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          errs = 0;
          if (out_tdata[16:0] !== want.sum) begin
            $display("%0t: window_sum expected %0d actual %0d",
                     $time, want.sum, out_tdata[16:0]);
            errs++;
          end
          if (out_tdata[18:17] !== want.phase) begin
            $display("%0t: phase expected %0d actual %0d",
                     $time, want.phase, out_tdata[18:17]);
            errs++;
          end
          if (out_tdata[19] !== want.fire) begin
            $display("%0t: fire_pulse expected %0d actual %0d",
                     $time, want.fire, out_tdata[19]);
            errs++;
          end
          if (out_tdata[23:20] !== 4'h0) begin
            $display("%0t: pad bits expected 0 actual %h", $time, out_tdata[23:20]);
            errs++;
          end
          mismatches += errs;
        end
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
// top of the temperature rise event detector test: clock, reset, sample stimulus,
// register settings and back-pressure; checking is done in tred_event_checker.sv
// depends on tred_pkg.sv, tred_event_checker.sv and the detector rtl
`timescale 1ns / 100ps

module testbench;
  import tred_pkg::*;

  localparam int unsigned WINDOW       = 30;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 150;
  // index past the register list, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {SEG_QUIET, SEG_RISE, SEG_FALL, SEG_NOISE} seg_kind_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // in_tdata: sample_code[11:0], zero pad [15:12]
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata: window_sum[16:0], phase[18:17], fire_pulse[19], zero pad [23:20]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr   = '0;
  logic [CFG_DAT_W-1:0]   cfg_wdata  = '0;

  int          mismatches;
  int          pending;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  int unsigned rx_roll;
  bit          tx_steady  = 1'b0;
  bit          rx_steady  = 1'b0;

  // sample shape generator state
  seg_kind_t seg_kind   = SEG_QUIET;
  int        seg_left   = 0;
  int        base_level = 1000;

  temperature_rise_event_detector #(.WINDOW(WINDOW)) u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  tred_event_checker #(.WINDOW(WINDOW)) u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .mismatches, .pending
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("temperature_rise_event_detector test failed");
    $finish;
  end

  // result side back-pressure, mostly short stalls and a few long ones
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 65) begin
        out_tready <= 1'b1;
      end else if (rx_roll < 94) begin
        out_tready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        stall_left <= $urandom_range(5, 30);
      end
    end
  end

  // idle cycles ahead of an input beat
  function automatic int pick_gap();
    int roll;
    if (tx_steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // quiet stretches of 25 to 45 samples, then a rise and a fall back, or at times some noise
  function automatic logic [SAMPLE_W-1:0] next_code();
    int v;
    if (seg_left == 0) begin
      case (seg_kind)
        SEG_QUIET: seg_kind = ($urandom_range(0, 9) == 0) ? SEG_NOISE : SEG_RISE;
        SEG_RISE:  seg_kind = SEG_FALL;
        SEG_FALL: begin
          seg_kind = SEG_QUIET;
          if ($urandom_range(0, 2) == 0) base_level = $urandom_range(0, 3500);
        end
        default:   seg_kind = SEG_QUIET;
      endcase
      case (seg_kind)
        SEG_QUIET: seg_left = $urandom_range(25, 45);
        SEG_RISE:  seg_left = $urandom_range(1, 3);
        SEG_FALL:  seg_left = $urandom_range(1, 6);
        default:   seg_left = $urandom_range(1, 10);
      endcase
    end
    seg_left--;
    case (seg_kind)
      SEG_QUIET: v = base_level + int'($urandom_range(0, 8)) - 4;
      SEG_RISE:  v = base_level + int'($urandom_range(0, 600));
      SEG_FALL:  v = base_level + int'($urandom_range(0, 60)) - 30;
      default:   v = $urandom_range(0, MAX_CODE);
    endcase
    if (v < 0) v = 0;
    if (v > int'(MAX_CODE)) v = MAX_CODE;
    return v[SAMPLE_W-1:0];
  endfunction

  // one input beat, held until taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-SAMPLE_W){1'b0}}, code};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // full register set plus a write past the list
  task automatic load_settings(input logic [CFG_DAT_W-1:0] hot, rise, settle);
    put_reg(REG_HOT_LEVEL, hot);
    put_reg(REG_UNUSED, 16'($urandom));
    put_reg(REG_RISE_MARGIN, rise);
    put_reg(REG_SETTLE_MARGIN, settle);
    cfg_we <= 1'b0;
  endtask

  // hold off until every result is back and the pipeline is empty
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [SAMPLE_W-1:0] directed_codes [16];
    directed_codes = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800, 12'h7FF, 12'hFFE,
                       12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h333, 12'h334, 12'hBB8, 12'h0F0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      tx_steady = (ph % 4 == 3);
      rx_steady = (ph % 3 == 2);
      // settings per phase, hot level often written with junk in the upper bits
      case (ph)
        0: load_settings(16'hF333, 16'd328, 16'd109);
        1: load_settings(16'h0000, 16'h0000, 16'h0000);
        2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: load_settings({4'($urandom), 12'd819}, 16'd328, 16'd109);
        4: load_settings(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                         16'($urandom_range(0, 2000)));
        5: load_settings(16'd100, 16'd16, 16'hFFFF);
        6: load_settings(16'($urandom), 16'($urandom), 16'($urandom));
        default: load_settings({4'($urandom), 12'd500}, 16'd800, 16'd0);
      endcase
      if (ph == 0) begin
        foreach (directed_codes[i]) send_sample(directed_codes[i]);
      end
      repeat (PHASE_ITEMS) send_sample(next_code());
      in_tvalid <= 1'b0;
      wait_drained();
    end

    if (mismatches == 0 && pending == 0)
      $display("temperature_rise_event_detector test passed");
    else
      $display("temperature_rise_event_detector test failed");
    $finish;
  end

endmodule
